// ----- design/ngh_pkg.sv -----
// Shared types, constants and helper functions for the noise gate.
// Used by ngh_front, ngh_queue, ngh_back and noise_gate_hold_hysteresis.
`timescale 1ns / 1ps
package ngh_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int QBITS       = 23;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // level scaling of |sample| to Q1.23
  localparam int LVL_SHR = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
  localparam int LVL_SHL = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;

  // shared multiplier: MUL_A_W x 24 unsigned
  localparam int MUL_A_W = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
  localparam int PROD_W  = MUL_A_W + 24;
  localparam int RQ_W    = PROD_W - QBITS;

  localparam logic [23:0] UNITY  = 24'd8388608;
  localparam int          HALF_Q = 4194304;
  localparam logic [63:0] MAXV64 = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // register map, index = paddr[4:2]
  localparam int          PADDR_W        = 5;
  localparam logic [2:0]  REG_OPEN_TH    = 3'd0;
  localparam logic [2:0]  REG_CLOSE_TH   = 3'd1;
  localparam logic [2:0]  REG_FLOOR      = 3'd2;
  localparam logic [2:0]  REG_ATTACK     = 3'd3;
  localparam logic [2:0]  REG_RELEASE    = 3'd4;
  localparam logic [2:0]  REG_DETECTOR   = 3'd5;
  localparam logic [2:0]  REG_HOLD       = 3'd6;
  localparam logic [2:0]  REG_BYPASS     = 3'd7;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef samp_t [CHANNELS-1:0] samp_vec_t;

  typedef struct packed {
    logic [23:0] open_th;
    logic [23:0] close_th;
    logic [23:0] floor_gain;
    logic [22:0] attack_coef;
    logic [22:0] release_coef;
    logic [22:0] detector_coef;
    logic [17:0] hold_samples;
    logic        bypass;
  } cfg_t;

  typedef struct packed {
    samp_vec_t   samples;
    logic [23:0] peak;
    logic        byp;
  } q_entry_t;

  function automatic logic [SAMPLE_BITS-1:0] mag_of(input samp_t s);
    return s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
  endfunction

  function automatic logic [23:0] level_of(input samp_t s);
    logic [SAMPLE_BITS-1:0] m;
    m = mag_of(s);
    return 24'((32'(m) << LVL_SHL) >> LVL_SHR);
  endfunction

endpackage

// ----- design/ngh_front.sv -----
// Front end: takes a frame transaction, finds the clamped peak level.
// Depends on ngh_pkg; feeds ngh_queue.
`timescale 1ns / 1ps
module ngh_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  ngh_pkg::samp_vec_t  samples,
  input  logic                bypass,
  input  logic                q_full,
  output logic                push,
  output ngh_pkg::q_entry_t   entry
);

  logic [23:0] peak;
  logic [23:0] lvl;

  always_comb begin
    peak = '0;
    for (int c = 0; c < ngh_pkg::CHANNELS; c++) begin
      lvl = ngh_pkg::level_of(samples[c]);
      if (lvl > peak) peak = lvl;
    end
    if (peak > ngh_pkg::UNITY) peak = ngh_pkg::UNITY;
  end

  assign in_stall      = q_full;
  assign push          = in_valid && !q_full;
  assign entry.samples = samples;
  assign entry.peak    = peak;
  assign entry.byp     = bypass;

endmodule

// ----- design/ngh_queue.sv -----
// Short register queue between the front end and the back end.
// Depends on ngh_pkg.
`timescale 1ns / 1ps
module ngh_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ngh_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ngh_pkg::q_entry_t head
);

  ngh_pkg::q_entry_t                 slots [ngh_pkg::Q_DEPTH];
  logic [ngh_pkg::Q_PTR_W-1:0]       wr_ptr;
  logic [ngh_pkg::Q_PTR_W-1:0]       rd_ptr;
  logic [ngh_pkg::Q_CNT_W-1:0]       count;

  function automatic logic [ngh_pkg::Q_PTR_W-1:0] bump(input logic [ngh_pkg::Q_PTR_W-1:0] p);
    return (p == ngh_pkg::Q_PTR_W'(ngh_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == ngh_pkg::Q_CNT_W'(ngh_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ----- design/ngh_back.sv -----
// Back end: envelope, hysteresis gate with hold, gain smoothing and the
// per-channel gain multiply on one shared multiplier. Depends on ngh_pkg.
`timescale 1ns / 1ps
module ngh_back (
  input  logic               clk,
  input  logic               rst,
  input  ngh_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  ngh_pkg::q_entry_t  q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ngh_pkg::samp_vec_t out_samples,
  output logic               gate_open,
  output logic [23:0]        current_gain
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_ENV    = 9'b000000010,
    ST_ENVR   = 9'b000000100,
    ST_GATE   = 9'b000001000,
    ST_GAIN   = 9'b000010000,
    ST_GAINR  = 9'b000100000,
    ST_APPLY  = 9'b001000000,
    ST_APPLYR = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state;

  logic [23:0] envelope;
  logic [23:0] gain;
  logic        is_open;
  logic [17:0] hold_left;
  logic [ngh_pkg::CH_W-1:0] ch;

  ngh_pkg::samp_vec_t w_samp;
  ngh_pkg::samp_vec_t res;
  logic [23:0]        w_peak;

  logic [ngh_pkg::MUL_A_W-1:0] mul_a;
  logic [23:0]                 mul_b;
  logic [ngh_pkg::PROD_W-1:0]  prod;
  logic [ngh_pkg::PROD_W-1:0]  rnd;
  logic [ngh_pkg::RQ_W-1:0]    rq;

  logic [23:0] target;
  logic [22:0] g_coef;
  logic        g_ge;
  logic [23:0] g_diff;

  logic                        neg;
  logic [ngh_pkg::RQ_W-1:0]    maxv;
  logic                        out_free;

  assign target = is_open ? ngh_pkg::UNITY
                : ((cfg.floor_gain > ngh_pkg::UNITY) ? ngh_pkg::UNITY : cfg.floor_gain);
  assign g_coef = (target > gain) ? cfg.attack_coef : cfg.release_coef;
  assign g_ge   = (gain >= target);
  assign g_diff = g_ge ? (gain - target) : (target - gain);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_ENV: begin
        mul_a = ngh_pkg::MUL_A_W'(envelope - w_peak);
        mul_b = {1'b0, cfg.detector_coef};
      end
      ST_GAIN: begin
        mul_a = ngh_pkg::MUL_A_W'(g_diff);
        mul_b = {1'b0, g_coef};
      end
      ST_APPLY: begin
        mul_a = ngh_pkg::MUL_A_W'(ngh_pkg::mag_of(w_samp[ch]));
        mul_b = gain;
      end
      default: ;
    endcase
  end

  // round half away from zero on magnitudes
  assign rnd  = prod + ngh_pkg::PROD_W'(ngh_pkg::HALF_Q);
  assign rq   = rnd[ngh_pkg::PROD_W-1:ngh_pkg::QBITS];
  assign neg  = w_samp[ch][ngh_pkg::SAMPLE_BITS-1];
  assign maxv = ngh_pkg::RQ_W'(ngh_pkg::MAXV64);
  assign out_free = !out_valid || !out_stall;
  assign pop  = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      envelope  <= '0;
      gain      <= ngh_pkg::UNITY;
      is_open   <= 1'b0;
      hold_left <= '0;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            w_samp <= q_head.samples;
            w_peak <= q_head.peak;
            if (q_head.byp) begin
              res   <= q_head.samples;
              state <= ST_DONE;
            end else begin
              state <= ST_ENV;
            end
          end
        end
        ST_ENV: state <= ST_ENVR;
        ST_ENVR: begin
          if (w_peak > envelope) envelope <= w_peak;
          else envelope <= w_peak + 24'(rq);
          state <= ST_GATE;
        end
        ST_GATE: begin
          if (envelope >= cfg.open_th) begin
            is_open   <= 1'b1;
            hold_left <= cfg.hold_samples;
          end else if (is_open && envelope < cfg.close_th) begin
            if (hold_left != '0) hold_left <= hold_left - 18'd1;
            else is_open <= 1'b0;
          end
          state <= ST_GAIN;
        end
        ST_GAIN: state <= ST_GAINR;
        ST_GAINR: begin
          gain  <= g_ge ? target + 24'(rq) : target - 24'(rq);
          ch    <= '0;
          state <= ST_APPLY;
        end
        ST_APPLY: state <= ST_APPLYR;
        ST_APPLYR: begin
          if (neg) begin
            if (rq > maxv + 1'b1) res[ch] <= ngh_pkg::SAMPLE_BITS'(maxv + 1'b1);
            else res[ch] <= ngh_pkg::SAMPLE_BITS'(ngh_pkg::RQ_W'(0) - rq);
          end else begin
            if (rq > maxv) res[ch] <= ngh_pkg::SAMPLE_BITS'(maxv);
            else res[ch] <= ngh_pkg::SAMPLE_BITS'(rq);
          end
          if (ch == ngh_pkg::CH_W'(ngh_pkg::CHANNELS - 1)) begin
            state <= ST_DONE;
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_APPLY;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_samples  <= res;
            gate_open    <= is_open;
            current_gain <= gain;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain <= ngh_pkg::UNITY) else $error("smoothed gain above unity");

  a_env_range: assert property (@(posedge clk) disable iff (rst)
    envelope <= ngh_pkg::UNITY) else $error("envelope above unity");

  a_closed_no_hold: assert property (@(posedge clk) disable iff (rst)
    !is_open |-> hold_left == '0) else $error("hold count left while closed");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != ST_IDLE) else $error("popped frame not taken into work");

endmodule

// ----- design/noise_gate_hold_hysteresis.sv -----
// The back end works on one frame at a time, sharing a single multiplier for
// envelope, gain smoothing and each channel in turn; bypassed frames skip
// straight to the result. A 2-entry queue buffers input while a frame is in
// work, and in_stall is raised while the queue is full.
// Reset (synchronous, rst high): registers to defaults, envelope 0, gain unity,
// gate closed, hold 0, queue and output empty.
`timescale 1ns / 1ps
module noise_gate_hold_hysteresis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ngh_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ngh_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [ngh_pkg::SAMPLE_BITS-1:0] right_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ngh_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [ngh_pkg::SAMPLE_BITS-1:0] right_out,
  output logic                                gate_open,
  output logic [23:0]                         current_gain
);

  ngh_pkg::cfg_t      cfg;
  ngh_pkg::samp_vec_t in_samples;
  ngh_pkg::samp_vec_t out_samples;
  ngh_pkg::q_entry_t  push_entry;
  ngh_pkg::q_entry_t  q_head;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  logic               wr_en;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_th       <= 24'd839;
      cfg.close_th      <= 24'd420;
      cfg.floor_gain    <= 24'd8389;
      cfg.attack_coef   <= 23'd8215651;
      cfg.release_coef  <= 23'd8386861;
      cfg.detector_coef <= 23'd8353728;
      cfg.hold_samples  <= 18'd2400;
      cfg.bypass        <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        ngh_pkg::REG_OPEN_TH:  cfg.open_th       <= pwdata[23:0];
        ngh_pkg::REG_CLOSE_TH: cfg.close_th      <= pwdata[23:0];
        ngh_pkg::REG_FLOOR:    cfg.floor_gain    <= pwdata[23:0];
        ngh_pkg::REG_ATTACK:   cfg.attack_coef   <= pwdata[22:0];
        ngh_pkg::REG_RELEASE:  cfg.release_coef  <= pwdata[22:0];
        ngh_pkg::REG_DETECTOR: cfg.detector_coef <= pwdata[22:0];
        ngh_pkg::REG_HOLD:     cfg.hold_samples  <= pwdata[17:0];
        default:               cfg.bypass        <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ngh_pkg::REG_OPEN_TH:  prdata = 32'(cfg.open_th);
      ngh_pkg::REG_CLOSE_TH: prdata = 32'(cfg.close_th);
      ngh_pkg::REG_FLOOR:    prdata = 32'(cfg.floor_gain);
      ngh_pkg::REG_ATTACK:   prdata = 32'(cfg.attack_coef);
      ngh_pkg::REG_RELEASE:  prdata = 32'(cfg.release_coef);
      ngh_pkg::REG_DETECTOR: prdata = 32'(cfg.detector_coef);
      ngh_pkg::REG_HOLD:     prdata = 32'(cfg.hold_samples);
      default:               prdata = 32'(cfg.bypass);
    endcase
  end

  assign in_samples[0] = left_sample;
  assign in_samples[1] = right_sample;
  assign left_out      = out_samples[0];
  assign right_out     = out_samples[1];

  ngh_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .samples  (in_samples),
    .bypass   (cfg.bypass),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  ngh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  ngh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_samples  (out_samples),
    .gate_open    (gate_open),
    .current_gain (current_gain)
  );

endmodule
